/* hdl/dls_pkg.sv */
package dls_pkg;

  // Default field widths.
  localparam int COORD_WIDTH_DEF = 32;
  localparam int COLOR_WIDTH_DEF = 16;
  localparam int FALLOFF_W       = 16;

  // Register index port width and register map.
  localparam int REG_INDEX_W = 3;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_LIGHT_DIR_X = 3'd0,
    REG_LIGHT_DIR_Y = 3'd1,
    REG_LIGHT_DIR_Z = 3'd2,
    REG_LIGHT_COLOR = 3'd3,
    REG_CAMERA_X    = 3'd4,
    REG_CAMERA_Y    = 3'd5,
    REG_CAMERA_Z    = 3'd6
  } reg_index_t;

  // Fixed-point formats: unit vector components are signed Q2.30, cosines and
  // powers are unsigned values up to 1.0 in 30 fraction bits.
  localparam int FRAC_BITS = 30;
  localparam int NORM_MSB  = 29;

  typedef logic signed [31:0] unit_t;
  typedef logic [30:0] q30_t;

  localparam q30_t  ONE30    = 31'h4000_0000;
  localparam unit_t UNIT_MAX = 32'sh4000_0000;

  // Pipeline depths of the arithmetic units.
  localparam int SQRT_LAT   = 31;
  localparam int DIV_LAT    = 31;
  localparam int UNIT_LAT   = 5 + SQRT_LAT + DIV_LAT + 1;
  localparam int POW_STEPS  = 8;
  localparam int POW_LAT    = POW_STEPS + POW_STEPS * (SQRT_LAT + 1);

endpackage

/* hdl/dls_delay.sv */
module dls_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] taps [DEPTH];

  // Shift line that moves only when the pipeline advances.
  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign dout = taps[DEPTH-1];

endmodule

/* hdl/dls_isqrt.sv */
module dls_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [61:0] x,
  output logic [30:0] root
);

  import dls_pkg::*;

  logic [32:0] rem [SQRT_LAT];
  logic [30:0] rt  [SQRT_LAT];
  logic [61:0] xs  [SQRT_LAT];

  // One result bit per stage, digit pairs taken from the top of the operand.
  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_step
    logic [32:0] r_rem;
    logic [30:0] r_rt;
    logic [61:0] r_xs;
    logic [34:0] trial;
    logic [34:0] tsub;
    logic [34:0] diff;
    logic        take;

    if (k == 0) begin : g_first
      assign r_rem = '0;
      assign r_rt  = '0;
      assign r_xs  = x;
    end else begin : g_next
      assign r_rem = rem[k-1];
      assign r_rt  = rt[k-1];
      assign r_xs  = xs[k-1];
    end

    always_comb begin
      trial = {r_rem, r_xs[61:60]};
      tsub  = {2'b00, r_rt, 2'b01};
      take  = (trial >= tsub);
      diff  = trial - tsub;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= take ? diff[32:0] : trial[32:0];
        rt[k]  <= {r_rt[29:0], take};
        xs[k]  <= {r_xs[59:0], 2'b00};
      end
    end
  end

  assign root = rt[SQRT_LAT-1];

endmodule

/* hdl/dls_div.sv */
module dls_div (
  input  logic        clk,
  input  logic        en,
  input  logic [29:0] num,
  input  logic [30:0] den,
  output logic [30:0] quo
);

  import dls_pkg::*;

  logic [31:0] rem [DIV_LAT];
  logic [30:0] dv  [DIV_LAT];
  logic [30:0] qv  [DIV_LAT];

  // Restoring division, one quotient bit per stage. The numerator never
  // exceeds the divisor, so the first step needs no shift.
  for (genvar k = 0; k < DIV_LAT; k++) begin : g_step
    logic [31:0] r_rem;
    logic [30:0] r_dv;
    logic [30:0] r_qv;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        take;

    if (k == 0) begin : g_first
      assign r_rem = {2'b00, num};
      assign r_dv  = den;
      assign r_qv  = '0;
      assign trial = {1'b0, r_rem};
    end else begin : g_next
      assign r_rem = rem[k-1];
      assign r_dv  = dv[k-1];
      assign r_qv  = qv[k-1];
      assign trial = {r_rem, 1'b0};
    end

    always_comb begin
      take = (trial >= {2'b00, r_dv});
      diff = trial - {2'b00, r_dv};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= take ? diff[31:0] : trial[31:0];
        dv[k]  <= r_dv;
        qv[k]  <= {r_qv[29:0], take};
      end
    end
  end

  assign quo = qv[DIV_LAT-1];

endmodule

/* hdl/dls_unit.sv */
module dls_unit #(
  parameter int IW = 33
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [IW-1:0] v [3],
  output dls_pkg::unit_t       u [3]
);

  import dls_pkg::*;

  localparam int PW     = $clog2(IW);
  localparam int SW     = IW + NORM_MSB;
  localparam int SIDE_W = 3 * 30 + 4;

  logic [IW-1:0]     abs_v [3];
  logic [IW-1:0]     m01;
  logic [IW-1:0]     mx;
  logic [IW-1:0]     a1 [3];
  logic [2:0]        neg1;
  logic [IW-1:0]     m1;
  logic [PW-1:0]     pos;
  logic [PW-1:0]     pos2;
  logic [IW-1:0]     a2 [3];
  logic [2:0]        neg2;
  logic              zero2;
  logic [SW-1:0]     wide [3];
  logic [29:0]       an [3];
  logic [SIDE_W-1:0] side3;
  logic [SIDE_W-1:0] side4;
  logic [SIDE_W-1:0] side5;
  logic [59:0]       sq4 [3];
  logic [61:0]       sum5;
  logic [30:0]       len;
  logic [SIDE_W-1:0] side_s;
  logic [30:0]       quo [3];
  logic [3:0]        flags_d;

  // Stage 1: magnitudes, signs and the largest magnitude.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_v[i] = v[i][IW-1] ? IW'(-v[i]) : IW'(v[i]);
    end
    m01 = (abs_v[0] > abs_v[1]) ? abs_v[0] : abs_v[1];
    mx  = (m01 > abs_v[2]) ? m01 : abs_v[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a1[i]   <= abs_v[i];
        neg1[i] <= v[i][IW-1];
      end
      m1 <= mx;
    end
  end

  // Stage 2: position of the leading one of the largest magnitude.
  always_comb begin
    pos = '0;
    for (int b = 0; b < IW; b++) begin
      if (m1[b]) begin
        pos = PW'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a2    <= a1;
      neg2  <= neg1;
      zero2 <= (m1 == '0);
      pos2  <= pos;
    end
  end

  // Stage 3: bring the leading one to bit 29, truncating on right shifts.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide[i] = (SW'(a2[i]) << NORM_MSB) >> pos2;
      an[i]   = wide[i][29:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3 <= {zero2, neg2, an[2], an[1], an[0]};
    end
  end

  // Stage 4: squares of the scaled components.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq4[i] <= 60'(side3[i*30 +: 30]) * 60'(side3[i*30 +: 30]);
      end
      side4 <= side3;
    end
  end

  // Stage 5: sum of squares.
  always_ff @(posedge clk) begin
    if (en) begin
      sum5  <= 62'(sq4[0]) + 62'(sq4[1]) + 62'(sq4[2]);
      side5 <= side4;
    end
  end

  // Vector length.
  dls_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .x    (sum5),
    .root (len)
  );

  dls_delay #(.WIDTH(SIDE_W), .DEPTH(SQRT_LAT)) u_side_dly (
    .clk  (clk),
    .en   (en),
    .din  (side5),
    .dout (side_s)
  );

  // Component over length, one divider per axis.
  for (genvar i = 0; i < 3; i++) begin : g_div
    dls_div u_div (
      .clk (clk),
      .en  (en),
      .num (side_s[i*30 +: 30]),
      .den (len),
      .quo (quo[i])
    );
  end

  dls_delay #(.WIDTH(4), .DEPTH(DIV_LAT)) u_flag_dly (
    .clk  (clk),
    .en   (en),
    .din  (side_s[SIDE_W-1 -: 4]),
    .dout (flags_d)
  );

  // Final stage: restore the signs; a zero vector stays zero.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (flags_d[3]) begin
          u[i] <= '0;
        end else if (flags_d[i]) begin
          u[i] <= -unit_t'({1'b0, quo[i]});
        end else begin
          u[i] <= unit_t'({1'b0, quo[i]});
        end
      end
    end
  end

endmodule

/* hdl/dls_pow.sv */
module dls_pow (
  input  logic              clk,
  input  logic              en,
  input  dls_pkg::q30_t     x,
  input  logic [15:0]       e,
  output dls_pkg::q30_t     p
);

  import dls_pkg::*;

  q30_t        ires  [POW_STEPS];
  q30_t        ibase [POW_STEPS];
  q30_t        ix    [POW_STEPS];
  logic [15:0] ie    [POW_STEPS];
  q30_t        fres  [POW_STEPS];
  q30_t        fr    [POW_STEPS];
  logic [15:0] fe    [POW_STEPS];

  // Integer part of the exponent: square and multiply, one bit per stage.
  for (genvar k = 0; k < POW_STEPS; k++) begin : g_int
    q30_t        r_res;
    q30_t        r_base;
    q30_t        r_x;
    logic [15:0] r_e;
    logic [61:0] pr;
    logic [61:0] pb;

    if (k == 0) begin : g_first
      assign r_res  = ONE30;
      assign r_base = x;
      assign r_x    = x;
      assign r_e    = e;
    end else begin : g_next
      assign r_res  = ires[k-1];
      assign r_base = ibase[k-1];
      assign r_x    = ix[k-1];
      assign r_e    = ie[k-1];
    end

    always_comb begin
      pr = 62'(r_res) * 62'(r_base);
      pb = 62'(r_base) * 62'(r_base);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ires[k]  <= r_e[8+k] ? q30_t'(pr >> FRAC_BITS) : r_res;
        ibase[k] <= q30_t'(pb >> FRAC_BITS);
        ix[k]    <= r_x;
        ie[k]    <= r_e;
      end
    end
  end

  // Fraction bits: repeated square roots of the base, most significant first.
  for (genvar j = 0; j < POW_STEPS; j++) begin : g_frac
    q30_t        r_res;
    q30_t        r_r;
    logic [15:0] r_e;
    logic [30:0] rr;
    q30_t        d_res;
    logic [15:0] d_e;
    logic [61:0] pm;

    if (j == 0) begin : g_first
      assign r_res = ires[POW_STEPS-1];
      assign r_r   = ix[POW_STEPS-1];
      assign r_e   = ie[POW_STEPS-1];
    end else begin : g_next
      assign r_res = fres[j-1];
      assign r_r   = fr[j-1];
      assign r_e   = fe[j-1];
    end

    dls_isqrt u_isqrt (
      .clk  (clk),
      .en   (en),
      .x    ({1'b0, r_r, 30'b0}),
      .root (rr)
    );

    dls_delay #(.WIDTH(31 + 16), .DEPTH(SQRT_LAT)) u_dly (
      .clk  (clk),
      .en   (en),
      .din  ({r_e, r_res}),
      .dout ({d_e, d_res})
    );

    always_comb begin
      pm = 62'(d_res) * 62'(rr);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        fres[j] <= d_e[POW_STEPS-1-j] ? q30_t'(pm >> FRAC_BITS) : d_res;
        fr[j]   <= rr;
        fe[j]   <= d_e;
      end
    end
  end

  assign p = fres[POW_STEPS-1];

endmodule

/* hdl/directional_light_shading_unit.sv */
// Shades one surface hit per item under a directional light: diffuse when
// tuser is 0, Blinn-Phong specular when tuser is 1. The pipeline takes a new
// item in every cycle unless a stall holds it, and returns the results in
// order; the depth comes from two normalizations in series (each a 31-stage
// square root and a 31-stage divider) followed by the exponent unit with its
// eight chained 31-stage square roots. A stall on the result side holds the
// whole pipeline; input tready follows it. Configuration registers must be
// written only while no item is in flight; the block does not enforce it.
module directional_light_shading_unit #(
  parameter int COORD_WIDTH = dls_pkg::COORD_WIDTH_DEF,
  parameter int COLOR_WIDTH = dls_pkg::COLOR_WIDTH_DEF,
  localparam int IN_BITS = 6 * COORD_WIDTH + 3 * COLOR_WIDTH + dls_pkg::FALLOFF_W,
  localparam int IN_W    = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_W   = ((3 * COLOR_WIDTH + 7) / 8) * 8,
  localparam int CFG_W   = (COORD_WIDTH > 3 * COLOR_WIDTH) ? COORD_WIDTH : 3 * COLOR_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [dls_pkg::REG_INDEX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // normal_x, normal_y, normal_z, hit_x, hit_y, hit_z, coef_r, coef_g, coef_b, falloff
  input  logic [IN_W-1:0]               s_axis_tdata,
  // func
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_r, out_g, out_b
  output logic [OUT_W-1:0]              m_axis_tdata
);

  import dls_pkg::*;

  localparam int CW        = COORD_WIDTH;
  localparam int CLW       = COLOR_WIDTH;
  localparam int UW        = CW + 1;
  localparam int OFS_COEF  = 6 * CW;
  localparam int OFS_FALL  = 6 * CW + 3 * CLW;
  localparam int LAT_TOTAL = 2 * UNIT_LAT + POW_LAT + 5;
  localparam int V_HU      = 2 * UNIT_LAT + 1;
  localparam int V_POW     = 2 * UNIT_LAT + 3 + POW_LAT;

  logic [CW-1:0]        light_dir [3];
  logic [3*CLW-1:0]     light_color;
  logic [CW-1:0]        camera [3];
  logic                 en;
  logic [LAT_TOTAL:0]   vpipe;

  logic [CW-1:0]        nin [3];
  logic [CW-1:0]        hin [3];
  logic [CLW-1:0]       col [3];
  logic [CLW-1:0]       coef [3];
  logic [2*CLW-1:0]     tp [3];
  logic signed [UW-1:0] nrm [3];
  logic signed [UW-1:0] lgt [3];
  logic signed [UW-1:0] view [3];

  logic signed [UW-1:0] nrm0 [3];
  logic signed [UW-1:0] lgt0 [3];
  logic signed [UW-1:0] view0 [3];
  logic [3*CLW-1:0]     t0;
  logic                 func0;
  logic [FALLOFF_W-1:0] fall0;

  unit_t                nu [3];
  unit_t                lu [3];
  unit_t                vu [3];
  logic signed [32:0]   hv [3];
  unit_t                hu [3];
  unit_t                nu_d [3];
  unit_t                lu_d [3];
  logic                 func_a;
  logic                 func_b;
  logic [FALLOFF_W-1:0] fall_d;
  logic [3*CLW-1:0]     t_d;

  unit_t                sel [3];
  logic signed [63:0]   dprod [3];
  logic signed [63:0]   dsum;
  q30_t                 cos_c;
  q30_t                 cos_q;
  q30_t                 cos_d;
  q30_t                 pow_q;
  q30_t                 pval;
  logic [CLW+30:0]      fprod [3];
  logic [CLW:0]         fr [3];
  logic [CLW-1:0]       out_c [3];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      light_dir[0] <= '0;
      light_dir[1] <= CW'(32'shFFFF_0000);
      light_dir[2] <= '0;
      light_color  <= '1;
      for (int i = 0; i < 3; i++) begin
        camera[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_addr))
        REG_LIGHT_DIR_X: light_dir[0] <= cfg_data[CW-1:0];
        REG_LIGHT_DIR_Y: light_dir[1] <= cfg_data[CW-1:0];
        REG_LIGHT_DIR_Z: light_dir[2] <= cfg_data[CW-1:0];
        REG_LIGHT_COLOR: light_color  <= cfg_data[3*CLW-1:0];
        REG_CAMERA_X:    camera[0]    <= cfg_data[CW-1:0];
        REG_CAMERA_Y:    camera[1]    <= cfg_data[CW-1:0];
        REG_CAMERA_Z:    camera[2]    <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances unless a finished result is held.
  assign en            = !vpipe[LAT_TOTAL] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vpipe[LAT_TOTAL];

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[LAT_TOTAL-1:0], s_axis_tvalid};
    end
  end

  // Field unpacking and the vectors that feed the normalizers.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nin[i]  = s_axis_tdata[i*CW +: CW];
      hin[i]  = s_axis_tdata[(3+i)*CW +: CW];
      coef[i] = s_axis_tdata[OFS_COEF + i*CLW +: CLW];
      col[i]  = light_color[(2-i)*CLW +: CLW];
      tp[i]   = (2*CLW)'(col[i]) * (2*CLW)'(coef[i]);
      nrm[i]  = $signed({nin[i][CW-1], nin[i]});
      lgt[i]  = -$signed({light_dir[i][CW-1], light_dir[i]});
      view[i] = $signed({camera[i][CW-1], camera[i]}) - $signed({hin[i][CW-1], hin[i]});
    end
  end

  // Input register stage.
  always_ff @(posedge clk) begin
    if (en) begin
      nrm0  <= nrm;
      lgt0  <= lgt;
      view0 <= view;
      t0    <= {tp[2][2*CLW-1:CLW], tp[1][2*CLW-1:CLW], tp[0][2*CLW-1:CLW]};
      func0 <= s_axis_tuser;
      fall0 <= s_axis_tdata[OFS_FALL +: FALLOFF_W];
    end
  end

  // Unit normal, unit light vector and unit view vector in parallel.
  dls_unit #(.IW(UW)) u_unit_n (.clk(clk), .en(en), .v(nrm0),  .u(nu));
  dls_unit #(.IW(UW)) u_unit_l (.clk(clk), .en(en), .v(lgt0),  .u(lu));
  dls_unit #(.IW(UW)) u_unit_v (.clk(clk), .en(en), .v(view0), .u(vu));

  // Halfway vector, then its own normalization.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        hv[i] <= {lu[i][31], lu[i]} + {vu[i][31], vu[i]};
      end
    end
  end

  dls_unit #(.IW(33)) u_unit_h (.clk(clk), .en(en), .v(hv), .u(hu));

  dls_delay #(.WIDTH(6 * 32), .DEPTH(UNIT_LAT + 1)) u_nl_dly (
    .clk  (clk),
    .en   (en),
    .din  ({lu[2], lu[1], lu[0], nu[2], nu[1], nu[0]}),
    .dout ({lu_d[2], lu_d[1], lu_d[0], nu_d[2], nu_d[1], nu_d[0]})
  );

  dls_delay #(.WIDTH(1), .DEPTH(2 * UNIT_LAT + 1)) u_func_a_dly (
    .clk (clk), .en (en), .din (func0), .dout (func_a)
  );

  dls_delay #(.WIDTH(FALLOFF_W), .DEPTH(2 * UNIT_LAT + 3)) u_fall_dly (
    .clk (clk), .en (en), .din (fall0), .dout (fall_d)
  );

  dls_delay #(.WIDTH(1), .DEPTH(POW_LAT + 2)) u_func_b_dly (
    .clk (clk), .en (en), .din (func_a), .dout (func_b)
  );

  dls_delay #(.WIDTH(3 * CLW), .DEPTH(2 * UNIT_LAT + 3 + POW_LAT)) u_t_dly (
    .clk (clk), .en (en), .din (t0), .dout (t_d)
  );

  // Cosine: products of the normal with the light or halfway vector.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sel[i] = func_a ? hu[i] : lu_d[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dprod[i] <= 64'(nu_d[i]) * 64'(sel[i]);
      end
    end
  end

  // Sum, clamp negative dots to zero and the top to 1.0.
  always_comb begin
    dsum = dprod[0] + dprod[1] + dprod[2];
    if (dsum[63] || dsum == '0) begin
      cos_c = '0;
    end else if (dsum[63:30] > 34'(ONE30)) begin
      cos_c = ONE30;
    end else begin
      cos_c = dsum[60:30];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= cos_c;
    end
  end

  // Specular exponent.
  dls_pow u_pow (
    .clk (clk),
    .en  (en),
    .x   (cos_q),
    .e   (fall_d),
    .p   (pow_q)
  );

  dls_delay #(.WIDTH(31), .DEPTH(POW_LAT)) u_cos_dly (
    .clk (clk), .en (en), .din (cos_q), .dout (cos_d)
  );

  // Scale the color products by the shading factor.
  assign pval = func_b ? pow_q : cos_d;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        fprod[i] <= (CLW+31)'(t_d[i*CLW +: CLW]) * (CLW+31)'(pval);
      end
    end
  end

  // Saturate into the output register.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fr[i]    = fprod[i][CLW+30:30];
      out_c[i] = fr[i][CLW] ? '1 : fr[i][CLW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= OUT_W'({out_c[2], out_c[1], out_c[0]});
    end
  end

  // An accepted item enters the first stage.
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> vpipe[0])
    else $error("accepted item did not enter the pipeline");

  // A held result freezes every stage.
  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vpipe))
    else $error("pipeline moved during a stall");

  // Normalized halfway components stay within plus and minus one.
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    vpipe[V_HU] |-> (hu[0] <= UNIT_MAX && hu[0] >= -UNIT_MAX &&
                     hu[1] <= UNIT_MAX && hu[1] >= -UNIT_MAX &&
                     hu[2] <= UNIT_MAX && hu[2] >= -UNIT_MAX))
    else $error("unit vector component out of range");

  // The power of a cosine never exceeds one.
  a_pow_range: assert property (@(posedge clk) disable iff (rst)
    vpipe[V_POW] |-> (pow_q <= ONE30))
    else $error("specular power above one");

endmodule
